/* design/prcu_pkg.sv */
// Package for the polyline rectangle clipper: widths, payload structs,
// register and source codes, sequencer states. No dependencies.
package prcu_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned MagW     = CoordW + 1;
  localparam int unsigned ProdW    = 2 * MagW;
  localparam int unsigned StepW    = $clog2(MagW);
  localparam int unsigned NumLines = 4;
  localparam int unsigned LineW    = $clog2(NumLines);
  localparam int unsigned EmitW    = $clog2(NumLines + 1);

  localparam logic [StepW-1:0] LastStep   = StepW'(MagW - 1);
  localparam logic [EmitW-1:0] VertexSlot = EmitW'(NumLines);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [MagW-1:0]   smag_t;
  typedef logic [MagW-1:0]          mag_t;
  typedef logic [ProdW-1:0]         prod_t;

  typedef enum logic [1:0] {
    CfgLeft,
    CfgBottom,
    CfgRight,
    CfgTop
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SrcVertex,
    SrcBottom,
    SrcLeft,
    SrcTop,
    SrcRight
  } src_e;

  typedef enum logic [3:0] {
    StIdle,
    StDelta,
    StMag,
    StLoad,
    StMul,
    StPrep,
    StDiv,
    StCoord,
    StCmp,
    StOrder,
    StEmit
  } state_e;

  typedef struct packed {
    coord_t vx;
    coord_t vy;
    logic   starts_polyline;
  } in_item_t;

  typedef struct packed {
    coord_t     px;
    coord_t     py;
    logic [2:0] source;
    logic       new_piece;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic prep;
    logic div_step;
  } lane_ctrl_t;

endpackage

/* design/prcu_lane.sv */
// One crossing lane: bit-serial shift-add multiply, then restoring divide
// with round-half-up bias. Depends on prcu_pkg.
module prcu_lane (
  input  logic                clk_i,
  input  prcu_pkg::lane_ctrl_t ctrl_i,
  input  prcu_pkg::mag_t      mcand_i,
  input  prcu_pkg::mag_t      mplier_i,
  input  prcu_pkg::mag_t      den_i,
  output prcu_pkg::prod_t     prod_o,
  output prcu_pkg::mag_t      quo_o
);

  localparam int unsigned MagW  = prcu_pkg::MagW;
  localparam int unsigned ProdW = prcu_pkg::ProdW;

  prcu_pkg::mag_t  mcand_q, mpl_q, den_q, rem_q, dvd_q;
  prcu_pkg::prod_t acc_q, prod_q;

  logic [MagW:0]   mul_sum;
  logic [MagW:0]   trial;
  logic [MagW:0]   diff;
  prcu_pkg::prod_t biased;

  always_comb begin
    mul_sum = {1'b0, acc_q[ProdW-1:MagW]} + (mpl_q[0] ? {1'b0, mcand_q} : '0);
    trial   = {rem_q, dvd_q[MagW-1]};
    diff    = trial - {1'b0, den_q};
    biased  = acc_q + ProdW'(den_q >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mcand_q <= mcand_i;
      mpl_q   <= mplier_i;
      den_q   <= den_i;
      acc_q   <= '0;
    end else if (ctrl_i.mul_step) begin
      acc_q <= {mul_sum, acc_q[MagW-1:1]};
      mpl_q <= mpl_q >> 1;
    end
    if (ctrl_i.prep) begin
      prod_q <= acc_q;
      rem_q  <= biased[ProdW-1:MagW];
      dvd_q  <= biased[MagW-1:0];
    end else if (ctrl_i.div_step) begin
      rem_q <= diff[MagW] ? trial[MagW-1:0] : diff[MagW-1:0];
      dvd_q <= {dvd_q[MagW-2:0], ~diff[MagW]};
    end
  end

  assign prod_o = prod_q;
  assign quo_o  = dvd_q;

endmodule

/* design/polyline_rectangle_clipper_unit.sv */
// Top level of the polyline rectangle clipper: sequencer, crossing ordering,
// result emission. Depends on prcu_pkg and prcu_lane.
//
// Each vertex clips the segment from the previous vertex against the
// rectangle and gives up to five points (edge crossings in order of the
// segment parameter, then the vertex if inside). One vertex is worked at a
// time; in_stall_o is high from acceptance until emission has passed the
// vertex slot, also while emission waits on a stalled output. The four
// crossing lanes run in parallel, each a bit-serial multiply followed by a
// restoring divide; emission then steps through the four crossing slots and
// the vertex slot. Configuration writes are always accepted.
module polyline_rectangle_clipper_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  prcu_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output prcu_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  prcu_pkg::coord_t     cfg_data_i
);

  localparam int unsigned CoordW   = prcu_pkg::CoordW;
  localparam int unsigned MagW     = prcu_pkg::MagW;
  localparam int unsigned NumLines = prcu_pkg::NumLines;
  localparam int unsigned LineW    = prcu_pkg::LineW;
  localparam int unsigned EmitW    = prcu_pkg::EmitW;

  function automatic prcu_pkg::mag_t magof(prcu_pkg::smag_t v);
    prcu_pkg::smag_t n;
    n = -v;
    return v[MagW-1] ? prcu_pkg::mag_t'(n) : prcu_pkg::mag_t'(v);
  endfunction

  function automatic prcu_pkg::smag_t sx(prcu_pkg::coord_t v);
    return {v[CoordW-1], v};
  endfunction

  prcu_pkg::state_e state_q, state_d;
  logic [prcu_pkg::StepW-1:0] step_q;
  logic [EmitW-1:0]           e_q;
  logic                       bp_q, bp_d;

  prcu_pkg::coord_t   lb_q, bb_q, rb_q, tb_q;
  prcu_pkg::coord_t   prev_x_q, prev_y_q;
  prcu_pkg::in_item_t item_q;

  prcu_pkg::smag_t dx_q, dy_q;
  prcu_pkg::smag_t num_q [NumLines];
  prcu_pkg::mag_t  mdx_q, mdy_q;
  prcu_pkg::mag_t  nm_q  [NumLines];
  logic [NumLines-1:0] valid_q, edge_q;
  prcu_pkg::coord_t    oc_q  [NumLines];
  logic                lt_q  [NumLines][NumLines];
  logic                inside_q;
  logic [NumLines-1:0] hit_q;
  logic [LineW-1:0]    idx_q [NumLines];

  prcu_pkg::lane_ctrl_t lane_ctrl;
  prcu_pkg::mag_t       l_mcand [NumLines];
  prcu_pkg::mag_t       l_mplier[NumLines];
  prcu_pkg::mag_t       l_den   [NumLines];
  prcu_pkg::prod_t      l_prod  [NumLines];
  prcu_pkg::mag_t       l_quo   [NumLines];

  prcu_pkg::coord_t line_val [NumLines];

  logic                out_valid_q, out_load;
  prcu_pkg::out_item_t out_q, out_d;

  logic                accept;
  logic [LineW-1:0]    cur_slot, cur_idx;
  logic                cur_emit, cur_break, later_emit, emit_go;
  logic [NumLines-1:0] slot_emit;

  assign line_val[0] = bb_q;
  assign line_val[1] = lb_q;
  assign line_val[2] = tb_q;
  assign line_val[3] = rb_q;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;

  // lanes
  for (genvar g = 0; g < NumLines; g++) begin : g_lane
    localparam bit Horiz = (g % 2) == 0;
    assign l_mcand[g]  = nm_q[g];
    assign l_mplier[g] = Horiz ? mdx_q : mdy_q;
    assign l_den[g]    = Horiz ? mdy_q : mdx_q;
    prcu_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .mcand_i  (l_mcand[g]),
      .mplier_i (l_mplier[g]),
      .den_i    (l_den[g]),
      .prod_o   (l_prod[g]),
      .quo_o    (l_quo[g])
    );
  end

  // emission lookup
  always_comb begin
    for (int s = 0; s < NumLines; s++) begin
      slot_emit[s] = hit_q[s] && edge_q[idx_q[s]];
    end
    cur_slot  = e_q[LineW-1:0];
    cur_idx   = idx_q[cur_slot];
    if (e_q == prcu_pkg::VertexSlot) begin
      cur_emit   = inside_q;
      cur_break  = !inside_q;
      later_emit = 1'b0;
    end else begin
      cur_emit   = slot_emit[cur_slot];
      cur_break  = hit_q[cur_slot] && !edge_q[cur_idx];
      later_emit = inside_q;
      for (int s = 0; s < NumLines; s++) begin
        if (LineW'(s) > cur_slot && slot_emit[s]) begin
          later_emit = 1'b1;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prcu_pkg::StIdle:  if (in_valid_i) state_d = prcu_pkg::StDelta;
      prcu_pkg::StDelta: state_d = prcu_pkg::StMag;
      prcu_pkg::StMag:   state_d = prcu_pkg::StLoad;
      prcu_pkg::StLoad:  state_d = prcu_pkg::StMul;
      prcu_pkg::StMul:   if (step_q == prcu_pkg::LastStep) state_d = prcu_pkg::StPrep;
      prcu_pkg::StPrep:  state_d = prcu_pkg::StDiv;
      prcu_pkg::StDiv:   if (step_q == prcu_pkg::LastStep) state_d = prcu_pkg::StCoord;
      prcu_pkg::StCoord: state_d = prcu_pkg::StCmp;
      prcu_pkg::StCmp:   state_d = prcu_pkg::StOrder;
      prcu_pkg::StOrder: state_d = prcu_pkg::StEmit;
      prcu_pkg::StEmit: begin
        if (emit_go && e_q == prcu_pkg::VertexSlot) state_d = prcu_pkg::StIdle;
      end
      default: state_d = prcu_pkg::StIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o         = (state_q != prcu_pkg::StIdle);
    lane_ctrl.load     = (state_q == prcu_pkg::StLoad);
    lane_ctrl.mul_step = (state_q == prcu_pkg::StMul);
    lane_ctrl.prep     = (state_q == prcu_pkg::StPrep);
    lane_ctrl.div_step = (state_q == prcu_pkg::StDiv);
    emit_go  = (state_q == prcu_pkg::StEmit) &&
               (!cur_emit || !out_valid_q || !out_stall_i);
    out_load = emit_go && cur_emit;
    bp_d     = bp_q;
    if (state_q == prcu_pkg::StDelta && item_q.starts_polyline) begin
      bp_d = 1'b1;
    end else if (out_load) begin
      bp_d = 1'b0;
    end else if (emit_go && cur_break) begin
      bp_d = 1'b1;
    end
    out_d.new_piece = bp_q;
    out_d.last      = !later_emit;
    if (e_q == prcu_pkg::VertexSlot) begin
      out_d.px     = item_q.vx;
      out_d.py     = item_q.vy;
      out_d.source = prcu_pkg::SrcVertex;
    end else begin
      out_d.px     = cur_idx[0] ? line_val[cur_idx] : oc_q[cur_idx];
      out_d.py     = cur_idx[0] ? oc_q[cur_idx] : line_val[cur_idx];
      out_d.source = 3'(cur_idx) + 3'(prcu_pkg::SrcBottom);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prcu_pkg::StIdle;
      step_q      <= '0;
      e_q         <= '0;
      bp_q        <= 1'b1;
      out_valid_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      lb_q        <= '0;
      bb_q        <= '0;
      rb_q        <= '0;
      tb_q        <= '0;
    end else begin
      state_q <= state_d;
      bp_q    <= bp_d;
      if ((state_q == prcu_pkg::StMul || state_q == prcu_pkg::StDiv) &&
          step_q != prcu_pkg::LastStep) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
      if (state_q == prcu_pkg::StOrder) begin
        e_q <= '0;
      end else if (emit_go) begin
        e_q <= e_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit_go && e_q == prcu_pkg::VertexSlot) begin
        prev_x_q <= item_q.vx;
        prev_y_q <= item_q.vy;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (prcu_pkg::cfg_idx_e'(cfg_index_i))
          prcu_pkg::CfgLeft:   lb_q <= cfg_data_i;
          prcu_pkg::CfgBottom: bb_q <= cfg_data_i;
          prcu_pkg::CfgRight:  rb_q <= cfg_data_i;
          prcu_pkg::CfgTop:    tb_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    logic [LineW-1:0]    rank;
    logic [NumLines-1:0] hit_n;
    logic                prec;
    prcu_pkg::smag_t     o, q;
    if (accept) begin
      item_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    unique case (state_q)
      prcu_pkg::StDelta: begin
        dx_q <= sx(item_q.vx) - sx(prev_x_q);
        dy_q <= sx(item_q.vy) - sx(prev_y_q);
        for (int i = 0; i < NumLines; i++) begin
          num_q[i] <= sx(line_val[i]) - ((i % 2) == 0 ? sx(prev_y_q) : sx(prev_x_q));
        end
      end
      prcu_pkg::StMag: begin
        mdx_q <= magof(dx_q);
        mdy_q <= magof(dy_q);
        for (int i = 0; i < NumLines; i++) begin
          nm_q[i] <= magof(num_q[i]);
        end
      end
      prcu_pkg::StLoad: begin
        for (int i = 0; i < NumLines; i++) begin
          valid_q[i] <= !item_q.starts_polyline && l_den[i] != '0 && nm_q[i] != '0 &&
                        (num_q[i][MagW-1] == ((i % 2) == 0 ? dy_q[MagW-1] : dx_q[MagW-1])) &&
                        nm_q[i] <= l_den[i];
        end
      end
      prcu_pkg::StCoord: begin
        for (int i = 0; i < NumLines; i++) begin
          o = (i % 2) == 0 ? sx(prev_x_q) : sx(prev_y_q);
          q = prcu_pkg::smag_t'(l_quo[i]);
          if ((i % 2) == 0 ? dx_q[MagW-1] : dy_q[MagW-1]) begin
            o = o - q;
          end else begin
            o = o + q;
          end
          oc_q[i] <= o[CoordW-1:0];
        end
      end
      prcu_pkg::StCmp: begin
        for (int a = 0; a < NumLines; a++) begin
          for (int b = 0; b < NumLines; b++) begin
            lt_q[a][b] <= ((a % 2) == (b % 2)) ? (nm_q[a] < nm_q[b]) :
                                                 (l_prod[a] < l_prod[b]);
          end
          if ((a % 2) == 0) begin
            edge_q[a] <= oc_q[a] >= lb_q && oc_q[a] <= rb_q;
          end else begin
            edge_q[a] <= oc_q[a] >= bb_q && oc_q[a] <= tb_q;
          end
        end
        inside_q <= item_q.vx >= lb_q && item_q.vx <= rb_q &&
                    item_q.vy >= bb_q && item_q.vy <= tb_q;
      end
      prcu_pkg::StOrder: begin
        hit_n = '0;
        for (int i = 0; i < NumLines; i++) begin
          rank = '0;
          for (int k = 0; k < NumLines; k++) begin
            prec = 1'b0;
            if (k < i) begin
              prec = valid_q[k] && !lt_q[i][k];
            end else if (k > i) begin
              prec = valid_q[k] && lt_q[k][i];
            end
            rank = rank + LineW'(prec);
          end
          if (valid_q[i]) begin
            hit_n[rank] = 1'b1;
            idx_q[rank] <= LineW'(i);
          end
        end
        hit_q <= hit_n;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_step_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == prcu_pkg::StLoad) |=> (step_q == '0))
    else $error("step counter not clear at multiply start");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == prcu_pkg::StEmit) |-> (e_q <= prcu_pkg::VertexSlot))
    else $error("emit index out of range");

  a_start_no_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == prcu_pkg::StEmit && item_q.starts_polyline) |-> (hit_q == '0))
    else $error("crossing emitted for a polyline start");

  // remaining slots after the last point emit nothing and never wait
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.last) |-> ##[1:5] (state_q == prcu_pkg::StIdle))
    else $error("last point transfer did not end the item");

endmodule

/* tb/prcu_checker.sv */
// Checker for the polyline rectangle clipper: tracks configuration writes,
// predicts the clipped points of each vertex transfer and compares results.
// Depends on prcu_pkg.
`timescale 1ns / 100ps

module prcu_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  prcu_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  prcu_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [1:0]          cfg_index_i,
  input  prcu_pkg::coord_t    cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  longint rect_l, rect_b, rect_r, rect_t;
  longint last_x, last_y;
  bit     gap_pending;
  prcu_pkg::out_item_t clip_q[$];

  function automatic bit in_rect(longint x, longint y);
    return x >= rect_l && x <= rect_r && y >= rect_b && y <= rect_t;
  endfunction

  // o + d*num/den rounded half away from zero
  function automatic longint lerp_round(longint o, longint d, longint num, longint den);
    longint unsigned p, dm, q;
    bit neg;
    dm  = den < 0 ? -den : den;
    p   = (d < 0 ? -d : d) * (num < 0 ? -num : num);
    q   = (p + dm / 2) / dm;
    neg = ((d < 0) != (num < 0)) != (den < 0);
    if (d == 0 || num == 0) return o;
    return neg ? o - longint'(q) : o + longint'(q);
  endfunction

  function automatic void emit_point(longint x, longint y, prcu_pkg::src_e src);
    prcu_pkg::out_item_t r;
    r.px = prcu_pkg::coord_t'(x);
    r.py = prcu_pkg::coord_t'(y);
    r.source = src;
    r.new_piece = gap_pending;
    r.last = 1'b0;
    gap_pending = 1'b0;
    clip_q.insert(clip_q.size(), r);
  endfunction

  function automatic void clip_vertex(prcu_pkg::in_item_t it);
    longint x2, y2, x1, y1, dx, dy, line, num, den, cx, cy;
    longint unsigned nm[4], dm[4], tn, td;
    longint xs[4], ys[4];
    bit     edge_ok[4], tok;
    prcu_pkg::src_e srcs[4], ts;
    longint tx, ty;
    int n, j, base;
    x2 = longint'(it.vx);
    y2 = longint'(it.vy);
    base = clip_q.size();
    n = 0;
    if (it.starts_polyline) begin
      gap_pending = 1'b1;
    end else begin
      x1 = last_x; y1 = last_y;
      dx = x2 - x1; dy = y2 - y1;
      for (int i = 0; i < 4; i++) begin
        bit horiz;
        horiz = (i == 0 || i == 2);
        line = (i == 0) ? rect_b : (i == 1) ? rect_l : (i == 2) ? rect_t : rect_r;
        num = horiz ? line - y1 : line - x1;
        den = horiz ? dy : dx;
        if (den == 0) continue;
        if (den > 0 && !(num > 0 && num <= den)) continue;
        if (den < 0 && !(num < 0 && num >= den)) continue;
        if (horiz) begin
          cx = lerp_round(x1, dx, num, den); cy = line;
          tok = cx >= rect_l && cx <= rect_r;
        end else begin
          cy = lerp_round(y1, dy, num, den); cx = line;
          tok = cy >= rect_b && cy <= rect_t;
        end
        tn = num < 0 ? -num : num;
        td = den < 0 ? -den : den;
        ts = prcu_pkg::src_e'(i + 1);
        j = n;
        while (j > 0 && tn * dm[j-1] < nm[j-1] * td) begin
          nm[j] = nm[j-1]; dm[j] = dm[j-1]; xs[j] = xs[j-1]; ys[j] = ys[j-1];
          edge_ok[j] = edge_ok[j-1]; srcs[j] = srcs[j-1];
          j--;
        end
        nm[j] = tn; dm[j] = td; xs[j] = cx; ys[j] = cy;
        edge_ok[j] = tok; srcs[j] = ts;
        n++;
      end
      for (int i = 0; i < n; i++) begin
        if (edge_ok[i]) emit_point(xs[i], ys[i], srcs[i]);
        else gap_pending = 1'b1;
      end
    end
    if (in_rect(x2, y2)) emit_point(x2, y2, prcu_pkg::SrcVertex);
    else gap_pending = 1'b1;
    last_x = x2;
    last_y = y2;
    if (clip_q.size() > base) clip_q[clip_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    prcu_pkg::out_item_t exp_r;
    if (!rst_ni) begin
      rect_l = 0; rect_b = 0; rect_r = 0; rect_t = 0;
      last_x = 0; last_y = 0;
      gap_pending = 1'b1;
      fail_count_o <= 0;
      clip_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (prcu_pkg::cfg_idx_e'(cfg_index_i))
          prcu_pkg::CfgLeft:   rect_l = longint'(cfg_data_i);
          prcu_pkg::CfgBottom: rect_b = longint'(cfg_data_i);
          prcu_pkg::CfgRight:  rect_r = longint'(cfg_data_i);
          prcu_pkg::CfgTop:    rect_t = longint'(cfg_data_i);
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (clip_q.size() == 0) begin
          $error("unexpected result px=%0d py=%0d", out_data_i.px, out_data_i.py);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = clip_q.pop_front();
          if (exp_r != out_data_i) begin
            if (exp_r.px != out_data_i.px)
              $error("px expected %0d got %0d", exp_r.px, out_data_i.px);
            if (exp_r.py != out_data_i.py)
              $error("py expected %0d got %0d", exp_r.py, out_data_i.py);
            if (exp_r.source != out_data_i.source)
              $error("source expected %0d got %0d", exp_r.source, out_data_i.source);
            if (exp_r.new_piece != out_data_i.new_piece)
              $error("new_piece expected %0d got %0d", exp_r.new_piece,
                     out_data_i.new_piece);
            if (exp_r.last != out_data_i.last)
              $error("last expected %0d got %0d", exp_r.last, out_data_i.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) clip_vertex(in_data_i);
      pending_o <= clip_q.size();
    end
  end

endmodule

/* tb/tb_polyline_rectangle_clipper_unit.sv */
// Testbench top for polyline_rectangle_clipper_unit: clock, reset, vertex and
// configuration stimulus, random output stalls, verdict.
// Depends on prcu_pkg, prcu_checker and the block.
`timescale 1ns / 100ps

module tb_polyline_rectangle_clipper_unit;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  prcu_pkg::in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  prcu_pkg::out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  prcu_pkg::coord_t    cfg_data_i = '0;
  int        fail_count, pending;
  bit        stall_on = 1'b1;

  always #2 clk_i = ~clk_i;

  polyline_rectangle_clipper_unit DUT (.*);

  prcu_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(5, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_on && $urandom_range(0, 5) == 0) out_stall_i <= ($urandom_range(0, 9) < 8);
    else if (!stall_on || $urandom_range(0, 2) == 0) out_stall_i <= 1'b0;
  end

  task automatic send_vertex(prcu_pkg::coord_t x, prcu_pkg::coord_t y, logic st);
    int g;
    g = gap_len();
    repeat (g) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= '{vx: x, vy: y, starts_polyline: st};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0 || in_stall_o) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_rect(prcu_pkg::coord_t l, prcu_pkg::coord_t b,
                          prcu_pkg::coord_t r, prcu_pkg::coord_t t);
    prcu_pkg::coord_t v[4];
    v = '{l, b, r, t};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i  <= v[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly vertices near the rectangle, some full range
  function automatic prcu_pkg::coord_t pick(prcu_pkg::coord_t lo, prcu_pkg::coord_t hi);
    longint span;
    case ($urandom_range(0, 9))
      0: return prcu_pkg::coord_t'($urandom);
      1: return lo;
      2: return hi;
      default: begin
        span = longint'(hi) - longint'(lo);
        return prcu_pkg::coord_t'(longint'(lo) - span / 2 +
                                  longint'($urandom_range(0, 1023)) * (2 * span + 1) / 1024);
      end
    endcase
  endfunction

  task automatic random_phase(prcu_pkg::coord_t l, prcu_pkg::coord_t b,
                              prcu_pkg::coord_t r, prcu_pkg::coord_t t, int cnt);
    set_rect(l, b, r, t);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 19) == 0) drain();
      send_vertex(pick(l, r), pick(b, t), ($urandom_range(0, 7) == 0));
    end
  endtask

  localparam prcu_pkg::coord_t CMax = 32'sh7fffffff;
  localparam prcu_pkg::coord_t CMin = 32'sh80000000;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset rectangle is the single point at origin; no start after reset
    send_vertex(0, 0, 1'b0);
    send_vertex(32'sh10000, 32'sh10000, 1'b0);
    set_rect(-32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000);
    send_vertex(-32'sh30000, 32'sh0, 1'b1);
    send_vertex(32'sh30000, 32'sh0, 1'b0);
    send_vertex(32'sh0, -32'sh30000, 1'b0);
    send_vertex(32'sh0, 32'sh30000, 1'b0);
    send_vertex(32'sh0, 32'sh30000, 1'b0);
    send_vertex(32'sh10000, 32'sh10000, 1'b0);
    send_vertex(32'sh5000, 32'sh5000, 1'b0);
    send_vertex(-32'sh20000, -32'sh20000, 1'b0);
    send_vertex(32'sh20000, 32'sh20001, 1'b0);
    send_vertex(32'sh10000, 32'sh20000, 1'b0);
    send_vertex(32'sh0, 32'sh0, 1'b1);
    send_vertex(32'sh10000, -32'sh10000, 1'b0);
    set_rect(CMin, CMin, CMax, CMax);
    send_vertex(CMin, CMin, 1'b1);
    send_vertex(CMax, CMax, 1'b0);
    send_vertex(CMin, CMax, 1'b0);
    send_vertex(32'sh1234, CMin, 1'b0);
    set_rect(32'sh10000, 32'sh10000, -32'sh10000, 32'sh20000);
    send_vertex(32'sh0, 32'sh0, 1'b1);
    send_vertex(32'sh0, 32'sh18000, 1'b0);
    send_vertex(-32'sh30000, 32'sh40000, 1'b0);
    random_phase(-32'sh40000, -32'sh20000, 32'sh30000, 32'sh50000, 25);
    stall_on = 1'b0;
    random_phase(CMin, -32'sh7, 32'sh3, CMax, 15);
    stall_on = 1'b1;
    random_phase(-32'sh64000000, -32'sh7ff00000, 32'sh64000000, 32'sh7ff00000, 20);
    random_phase(32'sh100, 32'sh100, 32'sh180, 32'sh180, 20);
    drain();
    if (fail_count == 0)
      $display("polyline_rectangle_clipper_unit verification clean");
    else
      $display("polyline_rectangle_clipper_unit verification failed");
    $finish;
  end

  initial begin
    #8000000;
    $display("polyline_rectangle_clipper_unit verification failed");
    $finish;
  end

endmodule

/* files.f */
design/prcu_pkg.sv
design/prcu_lane.sv
design/polyline_rectangle_clipper_unit.sv
tb/prcu_checker.sv
tb/tb_polyline_rectangle_clipper_unit.sv
